// ----- rtl/core/btok_pkg.sv -----
// Package for the byte stream tokenizer: token kind codes, register map,
// queue entry type and default sizes. No dependencies.
`timescale 1ns / 1ps

package btok_pkg;

	// Default length limit of one string, in bytes
	localparam int STRING_MAX_BYTES_DEF = 255;
	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_MAX_STRINGS = 1'b0;   // register index, paddr[2]
	localparam logic [7:0] MAX_STRINGS_RST = 8'd100;

	// Token kinds
	localparam logic [4:0] KIND_STRING      = 5'd0;
	localparam logic [4:0] KIND_WHILE       = 5'd1;
	localparam logic [4:0] KIND_INT         = 5'd2;
	localparam logic [4:0] KIND_VAR         = 5'd3;
	localparam logic [4:0] KIND_PLUS        = 5'd4;
	localparam logic [4:0] KIND_MINUS       = 5'd5;
	localparam logic [4:0] KIND_MUL         = 5'd6;
	localparam logic [4:0] KIND_DIV         = 5'd7;
	localparam logic [4:0] KIND_LPAREN      = 5'd8;
	localparam logic [4:0] KIND_RPAREN      = 5'd9;
	localparam logic [4:0] KIND_EQUAL       = 5'd10;
	localparam logic [4:0] KIND_LBRACE      = 5'd11;
	localparam logic [4:0] KIND_RBRACE      = 5'd12;
	localparam logic [4:0] KIND_END         = 5'd13;
	localparam logic [4:0] KIND_STRING_BYTE = 5'd14;
	localparam logic [4:0] KIND_TOO_MANY    = 5'd15;
	localparam logic [4:0] KIND_UNTERM      = 5'd16;

	// Everything one accepted byte gives: up to four flushed prefix letters,
	// then an int token, then one main token
	typedef struct packed {
		logic [2:0]      n_flush;
		logic [3:0][6:0] flush_letter;
		logic            has_int;
		logic [31:0]     int_value;
		logic            has_main;
		logic [4:0]      main_kind;
		logic [31:0]     main_value;
		logic [6:0]      main_letter;
	} btok_entry_t;

endpackage

// ----- rtl/core/btok_if.sv -----
// Channel interfaces of the byte stream tokenizer: byte in, token out.
// No dependencies.
`timescale 1ns / 1ps

interface btok_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink   (input valid, input char_byte, output ready);
endinterface

interface btok_token_if;
	logic               valid;
	logic               ready;
	logic [4:0]         token_kind;
	logic signed [31:0] token_value;
	logic [6:0]         var_letter;
	logic               last_of_run;

	modport source (output valid, output token_kind, output token_value,
		output var_letter, output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input token_value,
		input var_letter, input last_of_run, output ready);
endinterface

// ----- rtl/core/btok_front.sv -----
// Front end: takes one byte per transaction, keeps the lexer state and
// turns each byte that gives tokens into a queue entry. Uses btok_pkg and btok_byte_if.
`timescale 1ns / 1ps

module btok_front import btok_pkg::*; #(
	parameter int STRING_MAX_BYTES = STRING_MAX_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	btok_byte_if.sink         char_in,
	input  logic [7:0]        max_strings,
	output logic              push,
	output btok_entry_t       push_entry,
	input  logic              push_ready
);

	localparam int SBC_W = $clog2(STRING_MAX_BYTES + 1);

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_NUMBER = 3'd1;
	localparam logic [2:0] MODE_STRING = 3'd2;
	localparam logic [2:0] MODE_PREFIX = 3'd3;
	localparam logic [2:0] MODE_SKIP   = 3'd4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_MUL    = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DIV    = 8'h2F;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_P      = 8'h70;
	localparam logic [7:0] CH_W      = 8'h77;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Keyword letter at position idx (1..4) of while (w=0) or print (w=1)
	function automatic logic [7:0] kw_char(input logic w, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		case ({w, idx})
			4'b0_001: c = 8'h68; // h
			4'b0_010: c = 8'h69; // i
			4'b0_011: c = 8'h6C; // l
			4'b0_100: c = 8'h65; // e
			4'b1_001: c = 8'h72; // r
			4'b1_010: c = 8'h69; // i
			4'b1_011: c = 8'h6E; // n
			4'b1_100: c = 8'h74; // t
			default:  c = 8'h00;
		endcase
		return c;
	endfunction

	logic [2:0]       mode_q, mode_d;
	logic [2:0]       pfx_len_q, pfx_len_d;
	logic             pfx_word_q, pfx_word_d;
	logic [3:0][7:0]  pfx_bytes_q;
	logic [31:0]      accum_q, accum_d;
	logic [SBC_W-1:0] sbc_q, sbc_d;
	logic [7:0]       stotal_q, stotal_d;

	logic             pfx_we;
	logic [1:0]       pfx_wa;
	logic             accept;
	logic [7:0]       b;
	logic             b_digit;
	logic             use_idle;

	// what a byte does when handled as in idle
	logic [2:0]       id_mode;
	logic             id_emit;
	logic [4:0]       id_kind;
	logic [6:0]       id_letter;
	logic             id_str_start;
	logic             id_pfx_start;

	btok_entry_t      entry;

	assign b       = char_in.char_byte;
	assign accept  = char_in.valid && push_ready;
	assign b_digit = b inside {[8'h30:8'h39]};

	assign char_in.ready = push_ready;

	always_comb begin
		id_mode      = MODE_IDLE;
		id_emit      = 1'b0;
		id_kind      = KIND_VAR;
		id_letter    = 7'd0;
		id_str_start = 1'b0;
		id_pfx_start = 1'b0;
		if (b == CH_NUL || b == CH_LF) begin
			id_emit = 1'b1;
			id_kind = KIND_END;
		end else if (b == CH_QUOTE) begin
			id_mode      = MODE_STRING;
			id_str_start = 1'b1;
		end else if (b == CH_W || b == CH_P) begin
			id_mode      = MODE_PREFIX;
			id_pfx_start = 1'b1;
		end else if (b_digit) begin
			id_mode = MODE_NUMBER;
		end else if (b inside {[8'h61:8'h7A]}) begin
			id_emit   = 1'b1;
			id_kind   = KIND_VAR;
			id_letter = b[6:0];
		end else begin
			id_emit = 1'b1;
			case (b)
				CH_PLUS:   id_kind = KIND_PLUS;
				CH_MINUS:  id_kind = KIND_MINUS;
				CH_MUL:    id_kind = KIND_MUL;
				CH_DIV:    id_kind = KIND_DIV;
				CH_LPAREN: id_kind = KIND_LPAREN;
				CH_RPAREN: id_kind = KIND_RPAREN;
				CH_EQUAL:  id_kind = KIND_EQUAL;
				CH_LBRACE: id_kind = KIND_LBRACE;
				CH_RBRACE: id_kind = KIND_RBRACE;
				default:   id_emit = 1'b0;
			endcase
		end
	end

	always_comb begin
		mode_d     = mode_q;
		pfx_len_d  = pfx_len_q;
		pfx_word_d = pfx_word_q;
		accum_d    = accum_q;
		sbc_d      = sbc_q;
		stotal_d   = stotal_q;
		pfx_we     = 1'b0;
		pfx_wa     = 2'd0;
		use_idle   = 1'b0;
		entry      = '0;
		case (mode_q)
			MODE_NUMBER: begin
				if (b_digit) begin
					accum_d = (accum_q << 3) + (accum_q << 1) + {28'd0, b[3:0]};
				end else begin
					entry.has_int   = 1'b1;
					entry.int_value = accum_q;
					accum_d         = '0;
					use_idle        = 1'b1;
				end
			end
			MODE_STRING: begin
				if (b == CH_QUOTE) begin
					entry.has_main = 1'b1;
					if (stotal_q < max_strings) begin
						entry.main_kind  = KIND_STRING;
						entry.main_value = {24'd0, stotal_q};
						stotal_d         = stotal_q + 8'd1;
						mode_d           = MODE_IDLE;
					end else begin
						entry.main_kind = KIND_TOO_MANY;
						mode_d          = MODE_SKIP;
					end
				end else if (b == CH_NUL) begin
					entry.has_main  = 1'b1;
					entry.main_kind = KIND_UNTERM;
					mode_d          = MODE_IDLE;
				end else if (sbc_q < SBC_W'(STRING_MAX_BYTES)) begin
					entry.has_main   = 1'b1;
					entry.main_kind  = KIND_STRING_BYTE;
					entry.main_value = {24'd0, b};
					sbc_d            = sbc_q + SBC_W'(1);
				end
			end
			MODE_PREFIX: begin
				if (pfx_len_q inside {[3'd1:3'd4]} && b == kw_char(pfx_word_q, pfx_len_q)) begin
					if (pfx_len_q == 3'd4) begin
						entry.has_main = 1'b1;
						if (!pfx_word_q) begin
							entry.main_kind = KIND_WHILE;
						end else begin
							entry.main_kind   = KIND_VAR;
							entry.main_letter = CH_P[6:0];
						end
						mode_d    = MODE_IDLE;
						pfx_len_d = 3'd0;
					end else begin
						pfx_we    = 1'b1;
						pfx_wa    = pfx_len_q[1:0];
						pfx_len_d = pfx_len_q + 3'd1;
					end
				end else begin
					// mismatch: buffered letters go out as variables first
					entry.n_flush = (pfx_len_q > 3'd4) ? 3'd4 : pfx_len_q;
					for (int i = 0; i < 4; i++) begin
						entry.flush_letter[i] = pfx_bytes_q[i][6:0];
					end
					pfx_len_d = 3'd0;
					use_idle  = 1'b1;
				end
			end
			MODE_SKIP: begin
				if (b == CH_NUL || b == CH_LF) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				use_idle = 1'b1;
			end
		endcase

		if (use_idle) begin
			mode_d = id_mode;
			if (id_emit) begin
				entry.has_main    = 1'b1;
				entry.main_kind   = id_kind;
				entry.main_letter = id_letter;
			end
			if (id_str_start) begin
				sbc_d = '0;
			end
			if (id_pfx_start) begin
				pfx_word_d = (b == CH_P);
				pfx_we     = 1'b1;
				pfx_wa     = 2'd0;
				pfx_len_d  = 3'd1;
			end
			if (b_digit) begin
				accum_d = {28'd0, b[3:0]};
			end
		end
	end

	assign push_entry = entry;
	assign push = accept && (entry.n_flush != 3'd0 || entry.has_int || entry.has_main);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			pfx_len_q  <= 3'd0;
			pfx_word_q <= 1'b0;
			accum_q    <= '0;
			sbc_q      <= '0;
			stotal_q   <= '0;
		end else if (accept) begin
			mode_q     <= mode_d;
			pfx_len_q  <= pfx_len_d;
			pfx_word_q <= pfx_word_d;
			accum_q    <= accum_d;
			sbc_q      <= sbc_d;
			stotal_q   <= stotal_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pfx_we) begin
			pfx_bytes_q[pfx_wa] <= b;
		end
	end

endmodule

// ----- rtl/core/btok_queue.sv -----
// Small FIFO of queue entries between front and back end.
// Uses btok_pkg.
`timescale 1ns / 1ps

module btok_queue import btok_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  btok_entry_t push_entry,
	output logic        push_ready,
	input  logic        pop,
	output btok_entry_t pop_entry,
	output logic        pop_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	btok_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_entry  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/btok_back.sv -----
// Back end: walks the head queue entry and sends one token per transaction
// from an output register. Uses btok_pkg and btok_token_if.
`timescale 1ns / 1ps

module btok_back import btok_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  btok_entry_t head,
	input  logic        head_valid,
	output logic        pop,
	btok_token_if.source token_out
);

	logic [2:0]  pos_q;
	logic [2:0]  total;
	logic        last;
	logic        load;
	logic        out_valid_q;
	logic [4:0]  kind;
	logic [31:0] value;
	logic [6:0]  letter;

	assign total = head.n_flush + {2'b0, head.has_int} + {2'b0, head.has_main};
	assign last  = (pos_q == total - 3'd1);
	assign load  = head_valid && (!out_valid_q || token_out.ready);
	assign pop   = load && last;

	// order within one entry: flushed letters, int, main token
	always_comb begin
		kind   = head.main_kind;
		value  = head.main_value;
		letter = head.main_letter;
		if (pos_q < head.n_flush) begin
			kind   = KIND_VAR;
			value  = '0;
			letter = head.flush_letter[pos_q[1:0]];
		end else if (head.has_int && pos_q == head.n_flush) begin
			kind   = KIND_INT;
			value  = head.int_value;
			letter = 7'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= 3'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pos_q       <= last ? 3'd0 : pos_q + 3'd1;
			end else if (token_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			token_out.token_kind  <= kind;
			token_out.token_value <= value;
			token_out.var_letter  <= letter;
			token_out.last_of_run <= last;
		end
	end

	assign token_out.valid = out_valid_q;

endmodule

// ----- rtl/core/byte_stream_tokenizer_top.sv -----
// Byte stream tokenizer, top level: configuration registers and the
// front end / queue / back end chain. Uses btok_pkg, btok_if and submodules.
// A byte's tokens pass through the queue and the back end's output register.
// Throughput: one byte per cycle while each byte gives at most one token
// and token_out is not stalled; a byte with n tokens (n <= 5) holds the back
// end until all n are sent; the front keeps taking bytes until the queue is full.
// Reset (arst_n low, asynchronous): lexer idle, counters zero, max_strings 100.
`timescale 1ns / 1ps

module byte_stream_tokenizer_top import btok_pkg::*; #(
	parameter int STRING_MAX_BYTES = STRING_MAX_BYTES_DEF,
	parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	btok_byte_if.sink             char_in,
	btok_token_if.source          token_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// APB: register index sits in paddr[2]; the low bits are not decoded.
	// Writes land in the access phase; only max_strings exists.
	logic [7:0]  max_strings_q;
	logic        cfg_wr;

	// front -> queue -> back
	logic        push;
	logic        push_ready;
	btok_entry_t push_entry;
	logic        pop;
	logic        head_valid;
	btok_entry_t head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_strings_q <= MAX_STRINGS_RST;
		end else if (cfg_wr && paddr[2] == REG_MAX_STRINGS) begin
			max_strings_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_MAX_STRINGS) ? {24'd0, max_strings_q} : '0;

	// Front end: lexer state, one byte per transaction when the queue has room
	btok_front #(
		.STRING_MAX_BYTES (STRING_MAX_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_in     (char_in),
		.max_strings (max_strings_q),
		.push        (push),
		.push_entry  (push_entry),
		.push_ready  (push_ready)
	);

	// Decoupling queue; bytes without tokens never enter it
	btok_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_entry  (head),
		.pop_valid  (head_valid)
	);

	// Back end: one token per transaction from a registered output stage
	btok_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.token_out  (token_out)
	);

endmodule

// ----- tb/tb_byte_stream_tokenizer_top.sv -----
// Self-checking testbench for byte_stream_tokenizer_top: a typed table of
// directed bytes, then random phrases under several idling mixes and settings.
// Depends on btok_pkg, btok_if and the tokenizer RTL.
`timescale 1ns / 1ps

module tb_byte_stream_tokenizer_top;
	import btok_pkg::*;

	// No transaction on any port for this many cycles ends the run
	localparam int WATCHDOG_CYCLES = 2000;
	// Cycles allowed after the last token, for bytes that give no token
	localparam int SETTLE_CYCLES   = 10;
	// Random bytes per phase
	localparam int PHASE_BYTES     = 22;

	localparam logic [7:0]  NUL_BYTE   = 8'd0;
	localparam logic [7:0]  LINE_FEED  = 8'd10;
	localparam logic [39:0] WHILE_TEXT = "while";
	localparam logic [39:0] PRINT_TEXT = "print";
	localparam logic [71:0] SYMBOL_SET = "+-*/()={}";
	// max_strings is register 0, byte address 0
	localparam logic [APB_ADDR_W-1:0] ADDR_MAX_STRINGS = {REG_MAX_STRINGS, 2'b00};

	localparam logic TYPED     = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef enum logic [2:0] {
		LEX_IDLE,
		LEX_NUMBER,
		LEX_STRING,
		LEX_PREFIX,
		LEX_SKIP
	} lex_mode_e;

	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] value;
		logic [6:0]  letter;
		logic        last;
	} token_t;

	// A typed row carries the single token it must give, with last set
	typedef struct packed {
		logic [7:0]  ch;
		logic        typed;
		logic [4:0]  kind;
		logic [31:0] value;
	} directed_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	btok_byte_if  char_if();
	btok_token_if token_if();

	byte_stream_tokenizer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_if),
		.token_out (token_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Lexer mirror, brought to its reset values at time zero
	lex_mode_e   lex_mode;
	logic [7:0]  kw_buf [4];
	logic [2:0]  kw_len;
	logic        kw_print;
	logic [31:0] num_acc;
	int          str_bytes;
	logic [7:0]  str_total;
	logic [7:0]  max_strings_mirror;

	token_t step_tokens[$];      // tokens of the byte just taken
	token_t token_expect_q[$];   // tokens still owed by the block

	int tx_idle_pct;
	int rx_stall_pct;
	int calm_left;
	int bytes_sent;
	int tokens_checked;
	int fails;
	int quiet_cycles;

	// A line end, then the edge cases: every symbol, a four-letter prefix
	// broken by a letter (five tokens), a number closed by a quote, newline
	// and 0xFF inside a string, a second string over the limit of one, skip
	// to end of line, and a string cut off by a NUL.
	directed_row_t directed_rows [27] = '{
		'{LINE_FEED, TYPED,     KIND_END,         32'd0},
		'{"+",       TYPED,     KIND_PLUS,        32'd0},
		'{"-",       TYPED,     KIND_MINUS,       32'd0},
		'{"*",       TYPED,     KIND_MUL,         32'd0},
		'{"/",       TYPED,     KIND_DIV,         32'd0},
		'{"(",       TYPED,     KIND_LPAREN,      32'd0},
		'{")",       TYPED,     KIND_RPAREN,      32'd0},
		'{"=",       TYPED,     KIND_EQUAL,       32'd0},
		'{"{",       TYPED,     KIND_LBRACE,      32'd0},
		'{"}",       TYPED,     KIND_RBRACE,      32'd0},
		'{"w",       PREDICTED, '0,               '0},
		'{"h",       PREDICTED, '0,               '0},
		'{"i",       PREDICTED, '0,               '0},
		'{"l",       PREDICTED, '0,               '0},
		'{"x",       PREDICTED, '0,               '0},
		'{"9",       PREDICTED, '0,               '0},
		'{"\"",      PREDICTED, '0,               '0},
		'{8'hFF,     TYPED,     KIND_STRING_BYTE, 32'd255},
		'{LINE_FEED, TYPED,     KIND_STRING_BYTE, 32'd10},
		'{"\"",      TYPED,     KIND_STRING,      32'd0},
		'{"\"",      PREDICTED, '0,               '0},
		'{"\"",      TYPED,     KIND_TOO_MANY,    32'd0},
		'{"Q",       PREDICTED, '0,               '0},
		'{NUL_BYTE,  PREDICTED, '0,               '0},
		'{"\"",      PREDICTED, '0,               '0},
		'{NUL_BYTE,  TYPED,     KIND_UNTERM,      32'd0},
		'{NUL_BYTE,  TYPED,     KIND_END,         32'd0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Token predictor
	// ---------------------------------------------------------------

	function automatic void add_token(input logic [4:0] kind, input logic [31:0] value,
			input logic [6:0] letter);
		step_tokens.push_back('{kind, value, letter, 1'b0});
	endfunction

	// A byte seen with no token in progress
	function automatic void lex_fresh(input logic [7:0] b);
		lex_mode = LEX_IDLE;
		if (b == NUL_BYTE || b == LINE_FEED) begin
			add_token(KIND_END, '0, '0);
		end else if (b == "\"") begin
			lex_mode  = LEX_STRING;
			str_bytes = 0;
		end else if (b == "w" || b == "p") begin
			lex_mode  = LEX_PREFIX;
			kw_print  = (b == "p");
			kw_buf[0] = b;
			kw_len    = 3'd1;
		end else if (b >= "0" && b <= "9") begin
			lex_mode = LEX_NUMBER;
			num_acc  = 32'(b - "0");
		end else if (b >= "a" && b <= "z") begin
			add_token(KIND_VAR, '0, b[6:0]);
		end else begin
			// uppercase, blanks and anything else fall through silently
			case (b)
				"+": add_token(KIND_PLUS, '0, '0);
				"-": add_token(KIND_MINUS, '0, '0);
				"*": add_token(KIND_MUL, '0, '0);
				"/": add_token(KIND_DIV, '0, '0);
				"(": add_token(KIND_LPAREN, '0, '0);
				")": add_token(KIND_RPAREN, '0, '0);
				"=": add_token(KIND_EQUAL, '0, '0);
				"{": add_token(KIND_LBRACE, '0, '0);
				"}": add_token(KIND_RBRACE, '0, '0);
				default: ;
			endcase
		end
	endfunction

	// Keyword letters are held back until the word completes or breaks
	function automatic void lex_prefix(input logic [7:0] b);
		logic [39:0] text;
		int          i;
		text = kw_print ? PRINT_TEXT : WHILE_TEXT;
		if (b == text[39 - 8*kw_len -: 8]) begin
			if (kw_len == 3'd4) begin
				if (kw_print)
					add_token(KIND_VAR, '0, 7'("p"));
				else
					add_token(KIND_WHILE, '0, '0);
				lex_mode = LEX_IDLE;
				kw_len   = 3'd0;
			end else begin
				kw_buf[kw_len] = b;
				kw_len         = kw_len + 3'd1;
			end
		end else begin
			for (i = 0; i < int'(kw_len); i++)
				add_token(KIND_VAR, '0, kw_buf[i][6:0]);
			kw_len = 3'd0;
			lex_fresh(b);
		end
	endfunction

	function automatic void predict_tokens(input logic [7:0] b);
		step_tokens.delete();
		case (lex_mode)
			LEX_NUMBER: begin
				if (b >= "0" && b <= "9") begin
					num_acc = num_acc * 32'd10 + 32'(b - "0");
				end else begin
					add_token(KIND_INT, num_acc, '0);
					num_acc = '0;
					lex_fresh(b);
				end
			end
			LEX_STRING: begin
				if (b == "\"") begin
					if (str_total < max_strings_mirror) begin
						add_token(KIND_STRING, 32'(str_total), '0);
						str_total = str_total + 8'd1;
						lex_mode  = LEX_IDLE;
					end else begin
						add_token(KIND_TOO_MANY, '0, '0);
						lex_mode = LEX_SKIP;
					end
				end else if (b == NUL_BYTE) begin
					add_token(KIND_UNTERM, '0, '0);
					lex_mode = LEX_IDLE;
				end else if (str_bytes < STRING_MAX_BYTES_DEF) begin
					add_token(KIND_STRING_BYTE, 32'(b), '0);
					str_bytes++;
				end
			end
			LEX_PREFIX: lex_prefix(b);
			LEX_SKIP: begin
				if (b == NUL_BYTE || b == LINE_FEED)
					lex_mode = LEX_IDLE;
			end
			default: lex_fresh(b);
		endcase
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Byte sender
	// ---------------------------------------------------------------

	// Returns in the time step of the edge that accepted the transaction
	task automatic send_byte(input logic [7:0] b);
		// idle gaps come in spells, broken by short calm runs
		if (calm_left > 0) begin
			calm_left--;
		end else if ($urandom_range(0, 19) == 0) begin
			calm_left = 12;
		end else begin
			while ($urandom_range(0, 99) < tx_idle_pct) begin
				char_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		char_if.valid     <= 1'b1;
		char_if.char_byte <= b;
		do @(posedge clk); while (!char_if.ready);
		bytes_sent++;
	endtask

	task automatic feed_byte(input logic [7:0] b);
		send_byte(b);
		predict_tokens(b);
		foreach (step_tokens[k])
			token_expect_q.push_back(step_tokens[k]);
	endtask

	// Stop sending and let every owed token come out
	task automatic drain_tokens();
		char_if.valid <= 1'b0;
		do @(posedge clk); while (token_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write max_strings, read it straight back
	task automatic set_max_strings(input logic [7:0] setting);
		logic [APB_DATA_W-1:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_MAX_STRINGS;
		pwdata  <= {{(APB_DATA_W - 8){1'b0}}, setting};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		max_strings_mirror = setting;
		// back-to-back read: psel stays high
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback[7:0] !== max_strings_mirror) begin
			$error("max_strings: expected %0d, got %0d", max_strings_mirror, readback[7:0]);
			fails++;
		end
	endtask

	// One random phrase: mostly well-formed tokens with random content,
	// some broken keywords and plain noise
	task automatic send_phrase();
		int          pick;
		int          n;
		int          i;
		logic [39:0] text;
		logic [7:0]  b;
		pick = $urandom_range(0, 99);
		text = $urandom_range(0, 1) ? PRINT_TEXT : WHILE_TEXT;
		if (pick < 12) begin
			for (i = 0; i < 5; i++)
				feed_byte(text[39 - 8*i -: 8]);
		end else if (pick < 20) begin
			// keyword broken after one to four letters
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++)
				feed_byte(text[39 - 8*i -: 8]);
			feed_byte(8'($urandom_range(0, 255)));
		end else if (pick < 35) begin
			// one in five long enough to wrap past 32 bits
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
			repeat (n) feed_byte("0" + 8'($urandom_range(0, 9)));
		end else if (pick < 45) begin
			feed_byte("a" + 8'($urandom_range(0, 25)));
		end else if (pick < 60) begin
			n = $urandom_range(0, 8);
			feed_byte(SYMBOL_SET[8*n +: 8]);
		end else if (pick < 75) begin
			feed_byte("\"");
			n = $urandom_range(0, 6);
			repeat (n) begin
				b = 8'($urandom_range(1, 255));
				if (b == "\"")
					b = LINE_FEED;
				feed_byte(b);
			end
			feed_byte(($urandom_range(0, 9) == 0) ? NUL_BYTE : 8'("\""));
		end else if (pick < 85) begin
			feed_byte($urandom_range(0, 1) ? NUL_BYTE : LINE_FEED);
		end else begin
			feed_byte(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 3) == 0)
			feed_byte(" ");
	endtask

	task automatic run_phase(input logic [7:0] setting, input int idle_pct, input int stall_pct,
			input bit hold_mid);
		int  start;
		bit  held;
		set_max_strings(setting);
		tx_idle_pct  = idle_pct;
		rx_stall_pct = stall_pct;
		start = bytes_sent;
		held  = 1'b0;
		while (bytes_sent - start < PHASE_BYTES) begin
			send_phrase();
			// pressure: sender waits mid-phase for the block to run dry
			if (hold_mid && !held && bytes_sent - start >= PHASE_BYTES / 2) begin
				drain_tokens();
				held = 1'b1;
			end
		end
		// closes whatever line, string or skip is still open
		feed_byte(NUL_BYTE);
		drain_tokens();
	endtask

	// ---------------------------------------------------------------
	// Token checker: every accepted transaction against the oldest owed one
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		token_t want;
		if (token_if.valid && token_if.ready) begin
			tokens_checked++;
			if (token_expect_q.size() == 0) begin
				$error("unexpected token: kind %0d value %0d",
					token_if.token_kind, token_if.token_value);
				fails++;
			end else begin
				want = token_expect_q.pop_front();
				if (token_if.token_kind !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, token_if.token_kind);
					fails++;
				end
				if (token_if.token_value !== want.value) begin
					$error("token_value: expected %0d, got %0d",
						$signed(want.value), token_if.token_value);
					fails++;
				end
				if (token_if.var_letter !== want.letter) begin
					$error("var_letter: expected %0d, got %0d", want.letter, token_if.var_letter);
					fails++;
				end
				if (token_if.last_of_run !== want.last) begin
					$error("last_of_run: expected %0d, got %0d", want.last, token_if.last_of_run);
					fails++;
				end
			end
		end
		token_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// Watchdog: counts cycles with no transaction on any port
	always @(posedge clk) begin
		if ((char_if.valid && char_if.ready) || (token_if.valid && token_if.ready)
				|| (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("watchdog: no transaction for %0d cycles, %0d tokens still owed",
				quiet_cycles, token_expect_q.size());
			$display("[byte_stream_tokenizer_top] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------

	initial begin
		directed_row_t row;
		arst_n             = 1'b0;
		char_if.valid     <= 1'b0;
		char_if.char_byte <= '0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		lex_mode           = LEX_IDLE;
		kw_len             = 3'd0;
		kw_print           = 1'b0;
		num_acc            = '0;
		str_bytes          = 0;
		str_total          = '0;
		max_strings_mirror = MAX_STRINGS_RST;
		tx_idle_pct        = 0;
		rx_stall_pct       = 0;
		calm_left          = 0;
		bytes_sent         = 0;
		tokens_checked     = 0;
		fails              = 0;
		quiet_cycles       = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, limit of one string so the second one overflows
		set_max_strings(8'd1);
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.typed) begin
				send_byte(row.ch);
				predict_tokens(row.ch);   // keeps the mirror in step
				token_expect_q.push_back('{row.kind, row.value, 7'd0, 1'b1});
			end else begin
				feed_byte(row.ch);
			end
		end
		drain_tokens();

		// Random phases: limit zero, limit at the top with a mid-phase hold,
		// limit just above the strings so far, random limit
		run_phase(8'd0, 0, 0, 1'b0);
		run_phase(8'd255, 59, 0, 1'b1);
		run_phase(str_total + 8'd2, 0, 59, 1'b0);
		run_phase(8'($urandom_range(0, 255)), 35, 35, 1'b0);

		if (token_expect_q.size() != 0) begin
			$error("%0d expected tokens never arrived", token_expect_q.size());
			fails++;
		end
		$display("Summary: %0d bytes in, %0d tokens checked, %0d strings accepted",
			bytes_sent, tokens_checked, str_total);
		$display("Summary: five max_strings settings; no idling, sender gaps, stalls, both");
		if (fails == 0)
			$display("[byte_stream_tokenizer_top] OK");
		else
			$display("[byte_stream_tokenizer_top] ERROR");
		$finish;
	end

endmodule
